// ===== design/bcsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsf_pkg
// Shared types and constants of the corner smoothing filter.
// ----------------------------------------------------------------------------
package bcsf_pkg;

  localparam int GLYPH_ROWS = 64;
  localparam int GLYPH_COLS = 64;

  // fixed widths of the beat fields
  localparam int ROW_W     = 64;
  localparam int OUT_IDX_W = 6;

  // row counter width, wide enough for the glyph and for the output index
  localparam int CNT_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int IDX_W = (CNT_W > OUT_IDX_W) ? CNT_W : OUT_IDX_W;

  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(GLYPH_ROWS - 1);
  localparam logic [IDX_W-1:0] PREV_ROW = IDX_W'(GLYPH_ROWS - 2);
  localparam logic [IDX_W-1:0] TWO_ROWS = IDX_W'(2);

  // one column of the 5-row window: a is two rows above the center c
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } win_t;

  // tail of a glyph: two buffered rows still to be sent
  typedef enum logic [1:0] {
    FL_NONE,
    FL_SECOND,
    FL_LAST
  } flush_e;

endpackage

// ===== design/bcsf_cell.sv =====
// ----------------------------------------------------------------------------
// bcsf_cell
// One column of the filter: keeps four rows of history for its column and
// tests its center pixel against the neighbor columns' windows.
// ----------------------------------------------------------------------------
module bcsf_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          bit_i,
  input  logic          interior_i,
  input  bcsf_pkg::win_t left2_i,
  input  bcsf_pkg::win_t left1_i,
  input  bcsf_pkg::win_t right1_i,
  input  bcsf_pkg::win_t right2_i,
  output bcsf_pkg::win_t win_o,
  output logic          smooth_o
);

  // hist_q[0] is the previous row, hist_q[3] four rows back
  logic [3:0] hist_d, hist_q;

  logic [2:0] orth_sum, diag_sum, diag_want;
  logic       ctr, hit, side_ok;

  assign hist_d = {hist_q[2:0], bit_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (shift_i) begin
      hist_q <= hist_d;
    end
  end

  assign win_o = '{a: hist_q[3], b: hist_q[2], c: hist_q[1], d: hist_q[0], e: bit_i};

  assign ctr       = win_o.c;
  assign orth_sum  = 3'(win_o.b) + 3'(left1_i.c) + 3'(right1_i.c) + 3'(win_o.d);
  assign diag_sum  = 3'(left1_i.b) + 3'(right1_i.b) + 3'(left1_i.d) + 3'(right1_i.d);
  assign diag_want = ctr ? 3'd1 : 3'd3;

  // side of the single diagonal that matches the center
  always_comb begin
    if (left1_i.b == ctr) begin
      side_ok = (win_o.b == ctr) && (left1_i.c == ctr) && (left2_i.c == ctr) &&
                (win_o.a == ctr);
    end else if (right1_i.b == ctr) begin
      side_ok = (win_o.b == ctr) && (right1_i.c == ctr) && (right2_i.c == ctr) &&
                (win_o.a == ctr);
    end else if (left1_i.d == ctr) begin
      side_ok = (win_o.d == ctr) && (left1_i.c == ctr) && (left2_i.c == ctr) &&
                (win_o.e == ctr);
    end else begin
      side_ok = (win_o.d == ctr) && (right1_i.c == ctr) && (right2_i.c == ctr) &&
                (win_o.e == ctr);
    end
  end

  assign hit      = interior_i && (orth_sum == 3'd2) && (diag_sum == diag_want) && side_ok;
  assign smooth_o = ctr ^ hit;

endmodule

// ===== design/bitmap_corner_smoothing_filter.sv =====
// ----------------------------------------------------------------------------
// bitmap_corner_smoothing_filter
// Corner smoothing of a binary glyph, one row word per beat, rows sent out
// two rows late through a row of column cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_ready_o     | row_bits_i, first_row_i
//  out     | output    | out_valid_o / out_ready_i   | smoothed_bits_o,
//          |           |                             | out_row_index_o, glyph_done_o
//
//  one input beat per cycle while the output is free and no flush runs; result appears
//  in the output register the cycle after the input beat that causes it (the column
//  cells are one level of logic); the last row of a glyph adds two flush beats from
//  the cell history, and input is held off during the flush
//  reset clears the row count, the cell history and the output valid
//  a stalled output blocks input only while the output register is full
module bitmap_corner_smoothing_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] row_bits_i,
  input  logic        first_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] smoothed_bits_o,
  output logic [5:0]  out_row_index_o,
  output logic        glyph_done_o
);

  localparam int W  = bcsf_pkg::ROW_W;
  localparam int IW = bcsf_pkg::IDX_W;

  bcsf_pkg::win_t win [W];
  logic [W-1:0] smooth_row, lb1_row, lb0_row;

  bcsf_pkg::flush_e fl_d, fl_q;
  logic [IW-1:0] row_cnt_d, row_cnt_q;
  logic [IW-1:0] r_raw, r;
  logic          out_free, in_fire, load;
  logic [W-1:0]  bits_d, bits_q;
  logic [IW-1:0] idx_d;
  logic [5:0]    idx_q;
  logic          done_d, done_q, out_valid_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = out_free && (fl_q == bcsf_pkg::FL_NONE);
  assign in_fire    = in_valid_i && in_ready_o;

  // ---- row of column cells ----
  for (genvar j = 0; j < W; j++) begin : g_col
    bcsf_pkg::win_t l2, l1, r1, r2;
    if (j >= 2) begin : g_l2
      assign l2 = win[j-2];
    end else begin : g_l2z
      assign l2 = '0;
    end
    if (j >= 1) begin : g_l1
      assign l1 = win[j-1];
    end else begin : g_l1z
      assign l1 = '0;
    end
    if (j <= W - 2) begin : g_r1
      assign r1 = win[j+1];
    end else begin : g_r1z
      assign r1 = '0;
    end
    if (j <= W - 3) begin : g_r2
      assign r2 = win[j+2];
    end else begin : g_r2z
      assign r2 = '0;
    end

    bcsf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (in_fire),
      .bit_i      (row_bits_i[j]),
      .interior_i ((j >= 2) && (j <= bcsf_pkg::GLYPH_COLS - 3)),
      .left2_i    (l2),
      .left1_i    (l1),
      .right1_i   (r1),
      .right2_i   (r2),
      .win_o      (win[j]),
      .smooth_o   (smooth_row[j])
    );

    assign lb1_row[j] = win[j].c;
    assign lb0_row[j] = win[j].d;
  end

  // ---- row count ----
  always_comb begin
    r_raw = first_row_i ? '0 : row_cnt_q;
    r     = (int'(r_raw) >= bcsf_pkg::GLYPH_ROWS) ? '0 : r_raw;
  end

  assign row_cnt_d = (r == bcsf_pkg::LAST_ROW) ? '0 : r + IW'(1);

  // ---- flush sequencer: next state ----
  always_comb begin
    fl_d = fl_q;
    case (fl_q)
      bcsf_pkg::FL_NONE: begin
        if (in_fire && (r == bcsf_pkg::LAST_ROW)) fl_d = bcsf_pkg::FL_SECOND;
      end
      bcsf_pkg::FL_SECOND: begin
        if (out_free) fl_d = bcsf_pkg::FL_LAST;
      end
      bcsf_pkg::FL_LAST: begin
        if (out_free) fl_d = bcsf_pkg::FL_NONE;
      end
      default: fl_d = bcsf_pkg::FL_NONE;
    endcase
  end

  // ---- flush sequencer: output register load ----
  always_comb begin
    load   = 1'b0;
    bits_d = smooth_row;
    idx_d  = r - bcsf_pkg::TWO_ROWS;
    done_d = 1'b0;
    case (fl_q)
      bcsf_pkg::FL_NONE: begin
        load = in_fire && (r >= bcsf_pkg::TWO_ROWS);
        // first two rows of a glyph are border rows
        if (r < IW'(4)) bits_d = lb1_row;
      end
      bcsf_pkg::FL_SECOND: begin
        load   = out_free;
        bits_d = lb1_row;
        idx_d  = bcsf_pkg::PREV_ROW;
      end
      bcsf_pkg::FL_LAST: begin
        load   = out_free;
        bits_d = lb0_row;
        idx_d  = bcsf_pkg::LAST_ROW;
        done_d = 1'b1;
      end
      default: load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fl_q        <= bcsf_pkg::FL_NONE;
      row_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fl_q <= fl_d;
      if (in_fire) row_cnt_q <= row_cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= bits_d;
      idx_q  <= idx_d[5:0];
      done_q <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign smoothed_bits_o = bits_q;
  assign out_row_index_o = idx_q;
  assign glyph_done_o    = done_q;

  // ---- checks ----
  a_last_row_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (r == bcsf_pkg::LAST_ROW)) |=> (fl_q == bcsf_pkg::FL_SECOND))
    else $error("last row did not start the flush");

  a_done_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && glyph_done_o) |-> (out_row_index_o == bcsf_pkg::LAST_ROW[5:0]))
    else $error("glyph end on a row other than the last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= bcsf_pkg::LAST_ROW)
    else $error("row count beyond the glyph");

  a_no_input_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fl_q != bcsf_pkg::FL_NONE) |-> !in_fire)
    else $error("input beat taken during flush");

endmodule

// ===== bench/tb_bitmap_corner_smoothing_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_corner_smoothing_filter
// Streams glyph rows through the corner smoothing filter and checks every
// output row. A row-level model predicts each smoothed row, its index and the
// end-of-glyph flag. Short directed rows come first, then random glyphs built
// from blocks, staircases and noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_bitmap_corner_smoothing_filter;

  localparam int ROW_W       = bcsf_pkg::ROW_W;
  localparam int OUT_IDX_W   = bcsf_pkg::OUT_IDX_W;
  localparam int GLYPH_ROWS  = bcsf_pkg::GLYPH_ROWS;
  localparam int GLYPH_COLS  = bcsf_pkg::GLYPH_COLS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ROWS = 260;

  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic             first;
  } row_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]     bits;
    logic [OUT_IDX_W-1:0] idx;
    logic                 done;
  } out_row_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [ROW_W-1:0]     row_bits_i      = '0;
  logic                 first_row_i     = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic [ROW_W-1:0]     smoothed_bits_o;
  logic [OUT_IDX_W-1:0] out_row_index_o;
  logic                 glyph_done_o;

  bitmap_corner_smoothing_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .row_bits_i      (row_bits_i),
    .first_row_i     (first_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .smoothed_bits_o (smoothed_bits_o),
    .out_row_index_o (out_row_index_o),
    .glyph_done_o    (glyph_done_o)
  );

  row_beat_t        row_feed[$];
  out_row_t         expected_rows[$];
  logic [ROW_W-1:0] glyph[GLYPH_ROWS];

  // model state: last four input rows, newest first, and the next row index
  logic [ROW_W-1:0] row_history[4] = '{default: '0};
  int               row_count      = 0;

  row_beat_t next_beat;
  out_row_t  got_row;
  out_row_t  exp_row;
  int        fed_rows       = 0;
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        in_gap         = 0;
  int        out_stall      = 0;
  bit        in_quiet       = 1'b0;
  bit        out_quiet      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ROW_W-1:0] smooth_center(input logic [ROW_W-1:0] ar, br, cr,
                                                     dr, er);
    logic [ROW_W-1:0] res;
    int ctr, a3, b2, b3, b4, c1, c2, c4, c5, d2, d3, d4, e3;
    bit hit;
    res = cr;
    for (int c = 2; c <= GLYPH_COLS - 3; c++) begin
      ctr = int'(cr[c]);
      a3 = int'(ar[c]);   b2 = int'(br[c-1]); b3 = int'(br[c]);   b4 = int'(br[c+1]);
      c1 = int'(cr[c-2]); c2 = int'(cr[c-1]); c4 = int'(cr[c+1]); c5 = int'(cr[c+2]);
      d2 = int'(dr[c-1]); d3 = int'(dr[c]);   d4 = int'(dr[c+1]); e3 = int'(er[c]);
      if (b3 + c2 + c4 + d3 == 2 && b2 + b4 + d2 + d4 == 3 - 2 * ctr) begin
        // the single diagonal equal to the center picks the corner side
        if (b2 == ctr) begin
          hit = (b3 + c2 + c1 + a3 == 4 * ctr);
        end else if (b4 == ctr) begin
          hit = (b3 + c4 + c5 + a3 == 4 * ctr);
        end else if (d2 == ctr) begin
          hit = (d3 + c2 + c1 + e3 == 4 * ctr);
        end else begin
          hit = (d3 + c4 + c5 + e3 == 4 * ctr);
        end
        if (hit) res[c] = ~res[c];
      end
    end
    return res;
  endfunction

  task automatic predict_row(input logic [ROW_W-1:0] row, input logic first);
    int r;
    logic [ROW_W-1:0] bits;
    r = first ? 0 : row_count;
    if (r >= GLYPH_ROWS) r = 0;
    if (r >= 2) begin
      if (r >= 4) begin
        bits = smooth_center(row_history[3], row_history[2], row_history[1],
                             row_history[0], row);
      end else begin
        bits = row_history[1];
      end
      expected_rows.push_back('{bits, OUT_IDX_W'(r - 2), 1'b0});
    end
    if (r == GLYPH_ROWS - 1) begin
      // last row flushes the two rows still held back
      expected_rows.push_back('{row_history[0], OUT_IDX_W'(r - 1), 1'b0});
      expected_rows.push_back('{row, OUT_IDX_W'(r), 1'b1});
      row_count = 0;
    end else begin
      row_count = r + 1;
    end
    row_history[3] = row_history[2];
    row_history[2] = row_history[1];
    row_history[1] = row_history[0];
    row_history[0] = row;
  endtask

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 23) == 0) quiet = ~quiet;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic report(input string what);
    if (mismatch_count < 40) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic feed(input logic [ROW_W-1:0] bits, input logic first);
    row_feed.push_back('{bits, first});
    fed_rows++;
  endtask

  task automatic draw_glyph(input int style);
    int n, r0, c0, h, w, pos;
    bit flip, down;
    logic [ROW_W-1:0] mask;
    for (int r = 0; r < GLYPH_ROWS; r++) glyph[r] = '0;
    if (style == 2) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        case ($urandom_range(0, 2))
          0:       glyph[r] = {$urandom, $urandom};
          1:       glyph[r] = {$urandom, $urandom} & {$urandom, $urandom};
          default: glyph[r] = {$urandom, $urandom} | {$urandom, $urandom};
        endcase
      end
    end else begin
      if (style != 1) begin
        // filled blocks make corners; xor-ed ones punch holes with inner corners
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          r0   = $urandom_range(0, GLYPH_ROWS - 3);
          c0   = $urandom_range(0, GLYPH_COLS - 3);
          h    = $urandom_range(3, 14);
          w    = $urandom_range(3, 24);
          flip = ($urandom_range(0, 3) == 0);
          mask = ((ROW_W'(1) << w) - 1) << c0;
          for (int r = r0; r < r0 + h && r < GLYPH_ROWS; r++) begin
            glyph[r] = flip ? glyph[r] ^ mask : glyph[r] | mask;
          end
        end
      end
      if (style != 0) begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          c0   = $urandom_range(0, ROW_W - 1);
          down = ($urandom_range(0, 1) == 1);
          mask = (ROW_W'(1) << $urandom_range(1, 4)) - 1;
          for (int r = 0; r < GLYPH_ROWS; r++) begin
            pos = down ? (c0 + r) % ROW_W : (c0 + 2 * ROW_W - r) % ROW_W;
            glyph[r] |= (mask << pos) | (mask >> (ROW_W - pos));
          end
        end
      end
    end
  endtask

  // input side: one beat in flight, random gap after each accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) predict_row(row_bits_i, first_row_i);
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (row_feed.size() != 0) begin
          next_beat    = row_feed.pop_front();
          row_bits_i  <= next_beat.bits;
          first_row_i <= next_beat.first;
          in_valid_i  <= 1'b1;
          in_gap      <= draw_wait(in_quiet);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side: check each beat, then stall for a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_row = '{smoothed_bits_o, out_row_index_o, glyph_done_o};
        if (expected_rows.size() == 0) begin
          report($sformatf("unexpected beat, row %0d bits %h", got_row.idx, got_row.bits));
        end else begin
          exp_row = expected_rows.pop_front();
          if (got_row.bits !== exp_row.bits)
            report($sformatf("row %0d smoothed_bits got %h exp %h", exp_row.idx,
                             got_row.bits, exp_row.bits));
          if (got_row.idx !== exp_row.idx)
            report($sformatf("out_row_index got %0d exp %0d", got_row.idx, exp_row.idx));
          if (got_row.done !== exp_row.done)
            report($sformatf("row %0d glyph_done got %b exp %b", exp_row.idx,
                             got_row.done, exp_row.done));
        end
        out_stall = draw_wait(out_quiet);
        out_ready_i <= (out_stall == 0);
      end else if (out_stall != 0) begin
        out_stall   = out_stall - 1;
        out_ready_i <= (out_stall == 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int  len;
    bit  marked, last_whole;
    logic [ROW_W-1:0] block_rows;

    // extremes and border columns
    feed('1, 1'b1);
    feed('0, 1'b0);
    feed(64'h5555_5555_5555_5555, 1'b0);
    feed(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    feed(64'h8000_0000_0000_0001, 1'b0);
    // restart mid-glyph: 3x3 blocks at the first and last interior columns,
    // then their inverse so the corners turn concave
    block_rows = 64'h3800_0000_0000_001C;
    feed('0, 1'b1);
    feed('0, 1'b0);
    repeat (3) feed(block_rows, 1'b0);
    feed('0, 1'b0);
    feed('1, 1'b0);
    repeat (3) feed(~block_rows, 1'b0);
    feed('1, 1'b0);
    feed(64'h0000_0000_0000_0060, 1'b0);
    feed(64'h0000_0000_0000_0070, 1'b0);
    feed(64'h0000_0000_0000_0038, 1'b0);
    feed(64'h0000_0000_0000_001C, 1'b1);

    // random glyphs, mostly whole, some cut short or run on without a row-0 mark
    last_whole = 1'b0;
    while (fed_rows < RANDOM_ROWS) begin
      draw_glyph($urandom_range(0, 3));
      len    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, GLYPH_ROWS - 1) : GLYPH_ROWS;
      if (len > RANDOM_ROWS - fed_rows) len = RANDOM_ROWS - fed_rows;
      marked = ($urandom_range(0, last_whole ? 3 : 7) != 0);
      for (int r = 0; r < len; r++) begin
        feed(glyph[r], (r == 0) ? marked : ($urandom_range(0, 199) == 0));
      end
      last_whole = (len == GLYPH_ROWS);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (row_feed.size() != 0 || in_valid_i || expected_rows.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bcsf_pkg.sv
design/bcsf_cell.sv
design/bitmap_corner_smoothing_filter.sv
bench/tb_bitmap_corner_smoothing_filter.sv
